>>> hdl/rsdz_pkg.sv
// ============================================================================
// rsdz_pkg
// Shared widths, reset values and the per-word context for the radial
// scaled dead-zone pipeline.
// ============================================================================
package rsdz_pkg;

  localparam int AXIS_W      = 16;   // raw and scaled axis width
  localparam int ABS_W       = 16;   // absolute axis value, up to 32768
  localparam int DZ_W        = 15;   // dead-zone register width
  localparam int SUM_W       = 32;   // x*x + y*y
  localparam int FRAC_BITS   = 16;   // fraction bits of the magnitude
  localparam int ROOT_W      = 32;   // floor(sqrt(sum) * 2^16)
  localparam int REM_W       = ROOT_W + 3;
  localparam int PROD_W      = ROOT_W + ABS_W;  // excess * |axis|
  localparam int DEN_W       = ROOT_W + DZ_W;   // (full - dz) * magnitude
  localparam int NUM_W       = 64;              // excess * |axis| * full
  localparam int CNUM_W      = 32;              // |axis| * full

  localparam int DEF_FULL_SCALE_BITS = 16;
  localparam logic [DZ_W-1:0] DZ_RESET = 15'd2294;

  // Context that travels with every word through the pipeline.
  typedef struct packed {
    logic             tag;
    logic             neg_x;
    logic             neg_y;
    logic [ABS_W-1:0] abs_x;
    logic [ABS_W-1:0] abs_y;
    logic             dead;
    logic             zero;
  } ctx_t;

endpackage

>>> hdl/radial_scaled_dead_zone_core.sv
// ============================================================================
// radial_scaled_dead_zone_core
// Radial dead zone and rescaling of one two-axis stick sample per word.
// ============================================================================
// Usage:
// The input channel (in_valid / in_ready) carries one stick sample per word:
// stick_select, raw_x and raw_y. The output channel (out_valid / out_ready)
// returns exactly one word per sample: stick_tag, scaled_x, scaled_y and
// in_dead_zone. The dead_zone register is written through its own channel
// (cfg_valid / cfg_ready); cfg_ready is always high, and the register should
// only be written while no sample is in flight.
// Throughput is one word per cycle while the output is not stalled. The
// pipeline has three front stages (absolute values, squares, sum and
// dead-zone test), one stage per bit of the 32-bit magnitude square root,
// four stages of scaling multiplies and the overflow test, and one stage per
// quotient bit of the dividers. The accepting edge loads the first stage, and
// the last divider stage feeds the output register.
// The whole pipeline moves as one: it advances whenever the output register
// is empty or being taken. While the receiver stalls with a word waiting,
// every stage holds and in_ready is low, so nothing is lost or repeated.
// Synchronous reset clears all valid bits and restores dead_zone to 2294.
module radial_scaled_dead_zone_core #(
  parameter int AXIS_FULL_SCALE_BITS = rsdz_pkg::DEF_FULL_SCALE_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              stick_select,
  input  logic signed [rsdz_pkg::AXIS_W-1:0] raw_x,
  input  logic signed [rsdz_pkg::AXIS_W-1:0] raw_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              stick_tag,
  output logic signed [rsdz_pkg::AXIS_W-1:0] scaled_x,
  output logic signed [rsdz_pkg::AXIS_W-1:0] scaled_y,
  output logic                              in_dead_zone,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rsdz_pkg::DZ_W-1:0]         dead_zone
);
  import rsdz_pkg::*;

  // Full scale stands for 1.0; quotients carry one bit above it.
  localparam int FULL = (1 << (AXIS_FULL_SCALE_BITS - 1)) - 1;
  localparam int Q    = AXIS_FULL_SCALE_BITS;

  // Stage numbering: 0 absolute values, 1 squares, 2 sum, then the root.
  localparam int ST_SQ0 = 3;
  localparam int ST_E   = ST_SQ0 + ROOT_W;
  localparam int ST_M1  = ST_E + 1;
  localparam int ST_M2  = ST_E + 2;
  localparam int ST_D0  = ST_E + 3;
  localparam int NS     = ST_D0 + 1 + Q;

  // Divider state: the two main divisions and the two clamp divisions.
  typedef struct packed {
    logic [NUM_W-1:0]  rem_x;
    logic [NUM_W-1:0]  rem_y;
    logic [Q-1:0]      q_x;
    logic [Q-1:0]      q_y;
    logic [CNUM_W-1:0] crem_x;
    logic [CNUM_W-1:0] crem_y;
    logic [Q-1:0]      cq_x;
    logic [Q-1:0]      cq_y;
    logic [DEN_W-1:0]  den;
    logic [ABS_W-1:0]  big;
    logic              ovf_x;
    logic              ovf_y;
  } div_t;

  logic                en;
  logic [DZ_W-1:0]     dz;
  logic [2*DZ_W-1:0]   dz_sq;
  logic                vld [NS];
  ctx_t                ctx [NS];

  // The pipeline advances whenever the output register can take a word.
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // Dead-zone register and its square for the radial test.
  always_ff @(posedge clk) begin
    if (rst) begin
      dz <= DZ_RESET;
    end else if (cfg_valid) begin
      dz <= dead_zone;
    end
    dz_sq <= (2*DZ_W)'(dz) * (2*DZ_W)'(dz);
  end

  // Valid bits and context shift along with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  // Stage 0: sign and absolute value of both axes.
  // Stage 1: squares. Stage 2: sum and dead-zone test.
  logic [SUM_W-1:0] sq_x, sq_y, sum_c, sum_next;
  ctx_t             s2_ctx;
  assign sum_next = sq_x + sq_y;

  always_comb begin
    s2_ctx      = ctx[1];
    s2_ctx.dead = (dz >= DZ_W'(FULL)) || (sum_next < SUM_W'(dz_sq));
    s2_ctx.zero = (sum_next == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx[0].tag   <= stick_select;
      ctx[0].neg_x <= raw_x[AXIS_W-1];
      ctx[0].neg_y <= raw_y[AXIS_W-1];
      ctx[0].abs_x <= raw_x[AXIS_W-1] ? ABS_W'(-raw_x) : ABS_W'(raw_x);
      ctx[0].abs_y <= raw_y[AXIS_W-1] ? ABS_W'(-raw_y) : ABS_W'(raw_y);
      ctx[0].dead  <= 1'b0;
      ctx[0].zero  <= 1'b0;

      sq_x  <= SUM_W'(ctx[0].abs_x) * SUM_W'(ctx[0].abs_x);
      sq_y  <= SUM_W'(ctx[0].abs_y) * SUM_W'(ctx[0].abs_y);
      sum_c <= sum_next;
      ctx[1] <= ctx[0];
      ctx[2] <= s2_ctx;
      for (int i = 3; i < NS; i++) begin
        ctx[i] <= ctx[i-1];
      end
    end
  end

  // Square root of sum * 2^32, one result bit per stage.
  logic [SUM_W-1:0]  sr_sum  [ROOT_W];
  logic [REM_W-1:0]  sr_rem  [ROOT_W];
  logic [ROOT_W-1:0] sr_root [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [SUM_W-1:0]    sum_i;
    logic [REM_W-1:0]    rem_i;
    logic [ROOT_W-1:0]   root_i;
    logic [2*ROOT_W-1:0] rad;
    logic [REM_W-1:0]    shifted;
    logic [REM_W-1:0]    trial;
    if (k == 0) begin : g_first
      assign sum_i  = sum_c;
      assign rem_i  = '0;
      assign root_i = '0;
    end else begin : g_next
      assign sum_i  = sr_sum[k-1];
      assign rem_i  = sr_rem[k-1];
      assign root_i = sr_root[k-1];
    end
    assign rad     = {sum_i, {(2*ROOT_W-SUM_W){1'b0}}};
    assign shifted = {rem_i[REM_W-3:0], rad[2*ROOT_W-1-2*k -: 2]};
    assign trial   = REM_W'({root_i, 2'b01});
    always_ff @(posedge clk) begin
      if (en) begin
        sr_sum[k] <= sum_i;
        if (shifted >= trial) begin
          sr_rem[k]  <= shifted - trial;
          sr_root[k] <= {root_i[ROOT_W-2:0], 1'b1};
        end else begin
          sr_rem[k]  <= shifted;
          sr_root[k] <= {root_i[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // Excess over the dead zone and the scale denominator factor.
  logic [ROOT_W-1:0] e_mag, e_exc, dz_frac;
  logic [DZ_W-1:0]   e_fsub;
  assign dz_frac = ROOT_W'({dz, {FRAC_BITS{1'b0}}});

  // Scaling products, then the overflow test against den * 2^Q.
  logic [PROD_W-1:0] m1_px, m1_py;
  logic [DEN_W-1:0]  m1_den, m2_den;
  logic [CNUM_W-1:0] m1_cx, m1_cy, m2_cx, m2_cy;
  logic [ABS_W-1:0]  m1_big, m2_big;
  logic [NUM_W-1:0]  m2_nx, m2_ny, den_top;
  div_t              dv [Q+1];

  assign den_top = NUM_W'(m2_den) << Q;

  always_ff @(posedge clk) begin
    if (en) begin
      e_mag  <= sr_root[ROOT_W-1];
      e_exc  <= (sr_root[ROOT_W-1] > dz_frac) ? sr_root[ROOT_W-1] - dz_frac : '0;
      e_fsub <= DZ_W'(FULL) - dz;

      m1_px  <= PROD_W'(ctx[ST_E].abs_x) * PROD_W'(e_exc);
      m1_py  <= PROD_W'(ctx[ST_E].abs_y) * PROD_W'(e_exc);
      m1_den <= DEN_W'(e_fsub) * DEN_W'(e_mag);
      m1_cx  <= CNUM_W'(ctx[ST_E].abs_x) * CNUM_W'(FULL);
      m1_cy  <= CNUM_W'(ctx[ST_E].abs_y) * CNUM_W'(FULL);
      m1_big <= (ctx[ST_E].abs_x > ctx[ST_E].abs_y) ? ctx[ST_E].abs_x : ctx[ST_E].abs_y;

      m2_nx  <= (NUM_W'(m1_px) << (AXIS_FULL_SCALE_BITS - 1)) - NUM_W'(m1_px);
      m2_ny  <= (NUM_W'(m1_py) << (AXIS_FULL_SCALE_BITS - 1)) - NUM_W'(m1_py);
      m2_den <= m1_den;
      m2_cx  <= m1_cx;
      m2_cy  <= m1_cy;
      m2_big <= m1_big;

      dv[0].rem_x  <= m2_nx;
      dv[0].rem_y  <= m2_ny;
      dv[0].q_x    <= '0;
      dv[0].q_y    <= '0;
      dv[0].crem_x <= m2_cx;
      dv[0].crem_y <= m2_cy;
      dv[0].cq_x   <= '0;
      dv[0].cq_y   <= '0;
      dv[0].den    <= m2_den;
      dv[0].big    <= m2_big;
      dv[0].ovf_x  <= (m2_nx >= den_top);
      dv[0].ovf_y  <= (m2_ny >= den_top);
    end
  end

  // Restoring division, one quotient bit per stage for all four divisions.
  for (genvar j = 0; j < Q; j++) begin : g_div
    localparam int B = Q - 1 - j;
    div_t             cur;
    div_t             dv_next;
    logic [NUM_W-1:0] dsh;
    logic [CNUM_W-1:0] bsh;
    assign cur = dv[j];
    assign dsh = NUM_W'(cur.den) << B;
    assign bsh = CNUM_W'(cur.big) << B;
    always_comb begin
      dv_next = cur;
      if (cur.rem_x >= dsh) begin
        dv_next.rem_x  = cur.rem_x - dsh;
        dv_next.q_x[B] = 1'b1;
      end
      if (cur.rem_y >= dsh) begin
        dv_next.rem_y  = cur.rem_y - dsh;
        dv_next.q_y[B] = 1'b1;
      end
      if (cur.crem_x >= bsh) begin
        dv_next.crem_x  = cur.crem_x - bsh;
        dv_next.cq_x[B] = 1'b1;
      end
      if (cur.crem_y >= bsh) begin
        dv_next.crem_y  = cur.crem_y - bsh;
        dv_next.cq_y[B] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv[j+1] <= dv_next;
      end
    end
  end

  // Final selection: dead zone, zero vector, clamp or scaled quotient.
  div_t             fin;
  ctx_t             fc;
  logic             over_x, over_y, clamp;
  logic [Q-1:0]     sel_x, sel_y;
  logic [AXIS_W-1:0] mag_x, mag_y;

  assign fin    = dv[Q];
  assign fc     = ctx[NS-1];
  assign over_x = fin.ovf_x || (fin.q_x > Q'(FULL)) ||
                  ((fin.q_x == Q'(FULL)) && (fin.rem_x != '0));
  assign over_y = fin.ovf_y || (fin.q_y > Q'(FULL)) ||
                  ((fin.q_y == Q'(FULL)) && (fin.rem_y != '0));
  assign clamp  = over_x || over_y;

  always_comb begin
    sel_x = clamp ? fin.cq_x : fin.q_x;
    sel_y = clamp ? fin.cq_y : fin.q_y;
    if (fc.dead || fc.zero) begin
      sel_x = '0;
      sel_y = '0;
    end
    mag_x = AXIS_W'(sel_x);
    mag_y = AXIS_W'(sel_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[NS-1];
    end
    if (en) begin
      stick_tag    <= fc.tag;
      scaled_x     <= fc.neg_x ? -mag_x : mag_x;
      scaled_y     <= fc.neg_y ? -mag_y : mag_y;
      in_dead_zone <= fc.dead;
    end
  end

endmodule

>>> hdl/radial_scaled_dead_zone_checks.sv
// ============================================================================
// radial_scaled_dead_zone_checks
// Port-level checks on the output channel of the dead-zone core.
// ============================================================================
module radial_scaled_dead_zone_checks (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [15:0] scaled_x,
  input logic signed [15:0] scaled_y,
  input logic              in_dead_zone
);

  // A word in the dead zone always reports a zero vector.
  a_dead_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && in_dead_zone) |-> (scaled_x == 16'sd0 && scaled_y == 16'sd0))
    else $error("dead-zone word with nonzero axes");

  // Scaled axes never reach the most negative code.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (scaled_x != 16'sh8000 && scaled_y != 16'sh8000))
    else $error("scaled axis out of range");

  // While the output is stalled the input side is held off.
  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted during output stall");

  // A stalled output word stays presented.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(scaled_x) && $stable(scaled_y)))
    else $error("stalled output word dropped or changed");

  // Nothing comes out in the cycle right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind radial_scaled_dead_zone_core radial_scaled_dead_zone_checks u_checks (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .scaled_x    (scaled_x),
  .scaled_y    (scaled_y),
  .in_dead_zone(in_dead_zone)
);
